// File: hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RPST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RPST_CHK(lbl, prop, msg) `RPST_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: hw/rtl/rpst_pkg.sv
package rpst_pkg;

    localparam int DATA_W  = 32;
    localparam int SCALE_W = 24;
    localparam int RAD_W   = 8;
    localparam int SLOT_W  = 8;
    localparam int OUTC_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = DATA_W + SCALE_W;
    localparam int LIM_W   = RAD_W + FRAC_W;
    localparam int SQ_W    = 2 * LIM_W;

    localparam logic [CIDX_W-1:0] CFG_SCALE_X     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SCALE_Y     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SNAP_RADIUS = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = 8'd20;

    localparam logic [OUTC_W-1:0] OUTC_MATCH  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_APPEND = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_FULL   = 2'd2;

    typedef struct packed {
        logic load;
        logic run;
        logic take_hit;
        logic take_miss;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss_done;
    } t_sts;

endpackage

// File: hw/rtl/rpst_ram.sv
module rpst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rpst_ctrl.sv
module rpst_ctrl import rpst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.run = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = ST_DONE;
                end else if (i_sts.miss_done) begin
                    o_cmd.take_miss = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/rpst_dp.sv
module rpst_dp import rpst_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_idx,
    input  logic [SCALE_W-1:0]       i_cfg_data,
    input  logic signed [DATA_W-1:0] i_point_x,
    input  logic signed [DATA_W-1:0] i_point_y,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic signed [DATA_W-1:0] o_snapped_x,
    output logic signed [DATA_W-1:0] o_snapped_y,
    output logic [OUTC_W-1:0]        o_outcome,
    output logic [SLOT_W-1:0]        o_match_slot
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [SCALE_W-1:0] r_scale_x;
    logic [SCALE_W-1:0] r_scale_y;
    logic [RAD_W-1:0]   r_radius;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_rd_idx;
    logic [DATA_W-1:0]  r_px;
    logic [DATA_W-1:0]  r_py;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]     r_t1, r_t2, r_t3, r_t4;
    logic [DATA_W-1:0] r2_sx, r2_sy, r3_sx, r3_sy, r4_sx, r4_sy;
    logic [DATA_W-1:0] r2_dx, r2_dy;
    logic [PROD_W-1:0] r3_a, r3_b;
    logic              r4_over;
    logic [SQ_W-1:0]   r4_asq, r4_bsq;

    logic [DATA_W-1:0] r_res_x, r_res_y, r_out_x, r_out_y;
    logic [OUTC_W-1:0] r_res_outc, r_out_outc;
    logic [SLOT_W-1:0] r_res_slot, r_out_slot;

    logic                issue;
    logic                full;
    logic [2*DATA_W-1:0] rd_data;
    logic [DATA_W-1:0]   rd_x, rd_y;
    logic [DATA_W:0]     diff_x, diff_y, mag_x, mag_y;
    logic [PROD_W-1:0]   lim;
    logic [LIM_W-1:0]    a_lo, b_lo;
    logic [2*RAD_W-1:0]  rad_sq;
    logic [SQ_W:0]       dist_sq, lim_sq;

    assign issue = i_cmd.run && (r_rd_idx < r_count);
    assign full  = (r_count == CW'(MAX_POINTS));

    rpst_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take_miss && !full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_px, r_py}),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_x = rd_data[2*DATA_W-1:DATA_W];
    assign rd_y = rd_data[DATA_W-1:0];

    // 33-bit signed differences, magnitude fits in 32 bits
    assign diff_x = {rd_x[DATA_W-1], rd_x} - {r_px[DATA_W-1], r_px};
    assign diff_y = {rd_y[DATA_W-1], rd_y} - {r_py[DATA_W-1], r_py};
    assign mag_x  = diff_x[DATA_W] ? ((DATA_W+1)'(0) - diff_x) : diff_x;
    assign mag_y  = diff_y[DATA_W] ? ((DATA_W+1)'(0) - diff_y) : diff_y;

    assign lim  = PROD_W'({r_radius, FRAC_W'(0)});
    assign a_lo = r3_a[LIM_W-1:0];
    assign b_lo = r3_b[LIM_W-1:0];

    assign rad_sq  = (2*RAD_W)'(r_radius) * (2*RAD_W)'(r_radius);
    assign lim_sq  = (SQ_W+1)'({rad_sq, (2*FRAC_W)'(0)});
    assign dist_sq = (SQ_W+1)'(r4_asq) + (SQ_W+1)'(r4_bsq);

    assign o_sts.hit       = r_v4 && !r4_over && (dist_sq <= lim_sq);
    assign o_sts.miss_done = (r_rd_idx == r_count) && !(r_v1 || r_v2 || r_v3 || r_v4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= '0;
            r_scale_y <= '0;
            r_radius  <= RADIUS_RST;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SCALE_X) begin
                    r_scale_x <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_SCALE_Y) begin
                    r_scale_y <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_SNAP_RADIUS) begin
                    r_radius <= i_cfg_data[RAD_W-1:0];
                end
            end
            if (i_cmd.load) begin
                r_rd_idx <= '0;
            end else if (issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (i_cmd.take_miss && !full) begin
                r_count <= r_count + CW'(1);
            end
            r_v1 <= issue && !i_cmd.load;
            r_v2 <= r_v1 && !i_cmd.load;
            r_v3 <= r_v2 && !i_cmd.load;
            r_v4 <= r_v3 && !i_cmd.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        r_t1 <= r_rd_idx[AW-1:0];
        r_t2 <= r_t1;
        r_t3 <= r_t2;
        r_t4 <= r_t3;

        r2_sx <= rd_x;
        r2_sy <= rd_y;
        r2_dx <= mag_x[DATA_W-1:0];
        r2_dy <= mag_y[DATA_W-1:0];

        r3_sx <= r2_sx;
        r3_sy <= r2_sy;
        r3_a  <= PROD_W'(r2_dx) * PROD_W'(r_scale_x);
        r3_b  <= PROD_W'(r2_dy) * PROD_W'(r_scale_y);

        r4_sx   <= r3_sx;
        r4_sy   <= r3_sy;
        r4_over <= (r3_a > lim) || (r3_b > lim);
        r4_asq  <= SQ_W'(a_lo) * SQ_W'(a_lo);
        r4_bsq  <= SQ_W'(b_lo) * SQ_W'(b_lo);

        if (i_cmd.take_hit) begin
            r_res_x    <= r4_sx;
            r_res_y    <= r4_sy;
            r_res_outc <= OUTC_MATCH;
            r_res_slot <= SLOT_W'(r_t4);
        end else if (i_cmd.take_miss) begin
            r_res_x <= r_px;
            r_res_y <= r_py;
            if (full) begin
                r_res_outc <= OUTC_FULL;
                r_res_slot <= '0;
            end else begin
                r_res_outc <= OUTC_APPEND;
                r_res_slot <= SLOT_W'(r_count);
            end
        end

        if (i_cmd.publish) begin
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_outc <= r_res_outc;
            r_out_slot <= r_res_slot;
        end
    end

    assign o_snapped_x  = r_out_x;
    assign o_snapped_y  = r_out_y;
    assign o_outcome    = r_out_outc;
    assign o_match_slot = r_out_slot;

endmodule

// File: hw/rtl/radius_point_snap_table.sv
// Channel   Dir  Handshake                Payload
// cfg       in   i_cfg_we                 i_cfg_idx, i_cfg_data
// point     in   i_in_valid / o_in_ready  i_point_x, i_point_y
// snapped   out  o_out_valid / i_out_ready o_snapped_x, o_snapped_y, o_outcome, o_match_slot
//
// Each item scans the stored points in slot order until the first match, or through all of
// them on a miss. Stored points are read one per cycle from the single read port of the
// point RAM into a four-stage compare pipeline.
// Synchronous active-low reset empties the table and restores register defaults;
// the point RAM is not cleared.
// The result waits in an output register; the next item is taken meanwhile, but its
// result is held back until the output register is free.
module radius_point_snap_table import rpst_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_idx,
    input  logic [SCALE_W-1:0]       i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_point_x,
    input  logic signed [DATA_W-1:0] i_point_y,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_snapped_x,
    output logic signed [DATA_W-1:0] o_snapped_y,
    output logic [OUTC_W-1:0]        o_outcome,
    output logic [SLOT_W-1:0]        o_match_slot
);

    t_cmd cmd;
    t_sts sts;

    rpst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rpst_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_snapped_x  (o_snapped_x),
        .o_snapped_y  (o_snapped_y),
        .o_outcome    (o_outcome),
        .o_match_slot (o_match_slot)
    );

endmodule

// File: hw/rtl/rpst_checker.sv
`include "assert_macros.svh"

module rpst_checker import rpst_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [OUTC_W-1:0]        o_outcome,
    input logic [SLOT_W-1:0]        o_match_slot
);

    logic outc_ok;
    logic full_out;

    assign outc_ok  = (o_outcome == OUTC_MATCH) || (o_outcome == OUTC_APPEND) ||
                      (o_outcome == OUTC_FULL);
    assign full_out = o_out_valid && (o_outcome == OUTC_FULL);

    `RPST_CHK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")
    `RPST_CHK(a_outc_legal, o_out_valid |-> outc_ok, "illegal outcome")
    `RPST_CHK(a_full_slot, full_out |-> o_match_slot == '0, "full result with nonzero slot")
    `RPST_CHK(a_one_item, i_in_valid && o_in_ready |=> !o_in_ready, "second item during scan")

endmodule

bind radius_point_snap_table rpst_checker u_rpst_checker (.*);
